@@ sv/mau_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Modular arithmetic unit package
// Shared widths, payload structs, opcodes, datapath commands and FSM states.
// ----------------------------------------------------------------------------
package mau_pkg;

    localparam int RESIDUE_BITS = 31;
    localparam int OPERAND_BITS = 64;
    localparam int CNT_BITS     = 7;
    localparam int EUC_BITS     = RESIDUE_BITS + 3;

    typedef logic [RESIDUE_BITS-1:0] residue_t;

    localparam residue_t MODULUS_RESET = RESIDUE_BITS'(1000000007);

    typedef enum logic [2:0] {
        OP_REDUCE  = 3'd0,
        OP_ADD     = 3'd1,
        OP_SUB     = 3'd2,
        OP_NEG     = 3'd3,
        OP_MUL     = 3'd4,
        OP_DIV     = 3'd5,
        OP_POW     = 3'd6,
        OP_COMPARE = 3'd7
    } opcode_t;

    typedef struct packed {
        opcode_t                         opcode;
        logic signed [OPERAND_BITS-1:0]  operand_a;
        logic signed [OPERAND_BITS-1:0]  operand_b;
    } in_item_t;

    typedef struct packed {
        residue_t result;
        logic     equal;
        logic     less_than;
    } out_item_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_RED_A,
        DP_RED_B,
        DP_MUL_AB,
        DP_MUL_CA,
        DP_MUL_AA,
        DP_EUC_INIT,
        DP_EUC_DIV,
        DP_EUC_FIX,
        DP_POW_INIT,
        DP_FINISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } ctl_cmd_t;

    typedef struct packed {
        logic    busy;
        logic    modulus_small;
        logic    y_zero;
        logic    exp_zero;
        logic    exp_lsb;
        logic    out_free;
        opcode_t opcode;
    } ctl_status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RED_A,
        S_RED_B,
        S_DISPATCH,
        S_MUL,
        S_EUC_INIT,
        S_EUC_TEST,
        S_EUC_FIX,
        S_POW_INIT,
        S_POW_TEST,
        S_POW_MUL,
        S_POW_SQR,
        S_WAIT,
        S_FINISH
    } state_t;

    function automatic residue_t add_mod(residue_t a, residue_t b, residue_t m);
        logic [RESIDUE_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, m})
        begin
            s = s - {1'b0, m};
        end
        return s[RESIDUE_BITS-1:0];
    endfunction

endpackage
`default_nettype wire

@@ sv/mau_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Modular arithmetic unit datapath
// Bit-serial divider (reduction and Euclid quotient), bit-serial modular
// multiplier, operand and result registers.
// ----------------------------------------------------------------------------
module mau_datapath (
    input  wire                   clk,
    input  wire                   rst_n,
    input  mau_pkg::ctl_cmd_t     cmd,
    output mau_pkg::ctl_status_t  status,
    input  mau_pkg::residue_t     modulus,
    input  mau_pkg::in_item_t     in_data,
    output logic                  out_valid,
    input  wire                   out_stall,
    output mau_pkg::out_item_t    out_data
);
    import mau_pkg::*;

    typedef enum logic [1:0] {DD_A, DD_B, DD_EUC} div_dst_t;
    typedef enum logic {MD_ACC, MD_A} mul_dst_t;

    localparam int PAD_BITS = OPERAND_BITS - RESIDUE_BITS;

    opcode_t                   opcode_reg, opcode_next;
    logic [OPERAND_BITS-1:0]   a_reg, a_next, b_reg, b_next;
    residue_t                  ra_reg, ra_next, rb_reg, rb_next, acc_reg, acc_next;
    logic [OPERAND_BITS-1:0]   exp_reg, exp_next;

    logic [OPERAND_BITS-1:0]   dsr_reg, dsr_next;
    residue_t                  rem_reg, rem_next, dvs_reg, dvs_next;
    logic signed [EUC_BITS-1:0] tv_reg, tv_next;
    logic [CNT_BITS-1:0]       div_cnt_reg, div_cnt_next;
    logic                      div_busy_reg, div_busy_next;
    div_dst_t                  div_dst_reg, div_dst_next;
    logic                      neg_reg, neg_next;

    residue_t                  x_reg, x_next, y_reg, y_next;
    logic signed [EUC_BITS-1:0] u_reg, u_next, v_reg, v_next;

    residue_t                  mc_reg, mc_next, mb_reg, mb_next, mp_reg, mp_next;
    logic [CNT_BITS-1:0]       mul_cnt_reg, mul_cnt_next;
    logic                      mul_busy_reg, mul_busy_next;
    mul_dst_t                  mul_dst_reg, mul_dst_next;

    logic                      out_valid_reg, out_valid_next;
    out_item_t                 out_reg, out_next;

    logic [RESIDUE_BITS:0]     r2, r2_diff;
    logic                      ge;
    residue_t                  rem_step, red_val, fix_val, mp_step, mc_step;
    logic signed [EUC_BITS-1:0] tv_step, m_ext;
    logic [OPERAND_BITS-1:0]   a_mag, b_mag;
    logic [RESIDUE_BITS:0]     sum_ab, sub_wrap;
    out_item_t                 res;

    // divider step: shift in one dividend bit, subtract when it fits
    always_comb
    begin
        r2       = {rem_reg, dsr_reg[OPERAND_BITS-1]};
        r2_diff  = r2 - {1'b0, dvs_reg};
        ge       = (r2 >= {1'b0, dvs_reg});
        rem_step = ge ? r2_diff[RESIDUE_BITS-1:0] : r2[RESIDUE_BITS-1:0];
        tv_step  = (tv_reg <<< 1) + (ge ? v_reg : '0);
        red_val  = (neg_reg && rem_step != '0) ? (modulus - rem_step) : rem_step;
        m_ext    = EUC_BITS'(signed'({3'b000, modulus}));
        a_mag    = a_reg[OPERAND_BITS-1] ? (~a_reg + 1'b1) : a_reg;
        b_mag    = b_reg[OPERAND_BITS-1] ? (~b_reg + 1'b1) : b_reg;
        if (u_reg < 0)
        begin
            fix_val = residue_t'(u_reg + m_ext);
        end
        else if (u_reg >= m_ext)
        begin
            fix_val = residue_t'(u_reg - m_ext);
        end
        else
        begin
            fix_val = residue_t'(u_reg);
        end
        mp_step = mb_reg[0] ? add_mod(mp_reg, mc_reg, modulus) : mp_reg;
        mc_step = add_mod(mc_reg, mc_reg, modulus);
    end

    // final result per opcode
    always_comb
    begin
        sum_ab   = {1'b0, ra_reg} + {1'b0, rb_reg};
        sub_wrap = {1'b0, ra_reg} + {1'b0, modulus} - {1'b0, rb_reg};
        res      = '0;
        if (modulus >= RESIDUE_BITS'(2))
        begin
            case (opcode_reg)
                OP_REDUCE: res.result = ra_reg;
                OP_ADD:    res.result = (sum_ab >= {1'b0, modulus})
                                        ? residue_t'(sum_ab - {1'b0, modulus})
                                        : sum_ab[RESIDUE_BITS-1:0];
                OP_SUB:    res.result = (ra_reg >= rb_reg) ? (ra_reg - rb_reg)
                                        : sub_wrap[RESIDUE_BITS-1:0];
                OP_NEG:    res.result = (ra_reg == '0) ? '0 : (modulus - ra_reg);
                OP_MUL, OP_DIV, OP_POW: res.result = acc_reg;
                OP_COMPARE:
                begin
                    res.equal     = (ra_reg == rb_reg);
                    res.less_than = (ra_reg < rb_reg);
                end
                default: res = '0;
            endcase
        end
    end

    always_comb
    begin
        opcode_next   = opcode_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        ra_next       = ra_reg;
        rb_next       = rb_reg;
        acc_next      = acc_reg;
        exp_next      = exp_reg;
        dsr_next      = dsr_reg;
        rem_next      = rem_reg;
        dvs_next      = dvs_reg;
        tv_next       = tv_reg;
        div_cnt_next  = div_cnt_reg;
        div_busy_next = div_busy_reg;
        div_dst_next  = div_dst_reg;
        neg_next      = neg_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        u_next        = u_reg;
        v_next        = v_reg;
        mc_next       = mc_reg;
        mb_next       = mb_reg;
        mp_next       = mp_reg;
        mul_cnt_next  = mul_cnt_reg;
        mul_busy_next = mul_busy_reg;
        mul_dst_next  = mul_dst_reg;
        out_valid_next = out_valid_reg;
        out_next      = out_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        // advance divider
        if (div_busy_reg)
        begin
            dsr_next     = dsr_reg << 1;
            rem_next     = rem_step;
            tv_next      = tv_step;
            div_cnt_next = div_cnt_reg - 1'b1;
            if (div_cnt_reg == CNT_BITS'(1))
            begin
                div_busy_next = 1'b0;
                case (div_dst_reg)
                    DD_A: ra_next = red_val;
                    DD_B: rb_next = red_val;
                    DD_EUC:
                    begin
                        x_next = y_reg;
                        y_next = rem_step;
                        u_next = v_reg;
                        v_next = u_reg - tv_step;
                    end
                    default: ra_next = ra_reg;
                endcase
            end
        end

        // advance multiplier
        if (mul_busy_reg)
        begin
            mp_next      = mp_step;
            mc_next      = mc_step;
            mb_next      = mb_reg >> 1;
            mul_cnt_next = mul_cnt_reg - 1'b1;
            if (mul_cnt_reg == CNT_BITS'(1))
            begin
                mul_busy_next = 1'b0;
                if (mul_dst_reg == MD_A)
                begin
                    ra_next = mp_step;
                end
                else
                begin
                    acc_next = mp_step;
                end
            end
        end

        case (cmd.op)
            DP_LOAD:
            begin
                opcode_next = in_data.opcode;
                a_next      = in_data.operand_a;
                b_next      = in_data.operand_b;
            end
            DP_RED_A, DP_RED_B:
            begin
                dsr_next      = (cmd.op == DP_RED_A) ? a_mag : b_mag;
                neg_next      = (cmd.op == DP_RED_A) ? a_reg[OPERAND_BITS-1]
                                                     : b_reg[OPERAND_BITS-1];
                div_dst_next  = (cmd.op == DP_RED_A) ? DD_A : DD_B;
                rem_next      = '0;
                dvs_next      = modulus;
                tv_next       = '0;
                div_cnt_next  = CNT_BITS'(OPERAND_BITS);
                div_busy_next = 1'b1;
            end
            DP_EUC_INIT:
            begin
                x_next = rb_reg;
                y_next = modulus;
                u_next = EUC_BITS'(1);
                v_next = '0;
            end
            DP_EUC_DIV:
            begin
                dsr_next      = {x_reg, {PAD_BITS{1'b0}}};
                neg_next      = 1'b0;
                div_dst_next  = DD_EUC;
                rem_next      = '0;
                dvs_next      = y_reg;
                tv_next       = '0;
                div_cnt_next  = CNT_BITS'(RESIDUE_BITS);
                div_busy_next = 1'b1;
            end
            DP_EUC_FIX:
            begin
                rb_next = fix_val;
            end
            DP_POW_INIT:
            begin
                acc_next = RESIDUE_BITS'(1);
                exp_next = b_reg[OPERAND_BITS-1] ? '0 : b_reg;
            end
            DP_MUL_AB, DP_MUL_CA, DP_MUL_AA:
            begin
                mc_next       = ra_reg;
                mb_next       = (cmd.op == DP_MUL_AB) ? rb_reg
                              : (cmd.op == DP_MUL_CA) ? acc_reg : ra_reg;
                mul_dst_next  = (cmd.op == DP_MUL_AA) ? MD_A : MD_ACC;
                mp_next       = '0;
                mul_cnt_next  = CNT_BITS'(RESIDUE_BITS);
                mul_busy_next = 1'b1;
                if (cmd.op == DP_MUL_AA)
                begin
                    exp_next = exp_reg >> 1;
                end
            end
            DP_FINISH:
            begin
                out_valid_next = 1'b1;
                out_next       = res;
            end
            default: opcode_next = opcode_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg  <= 1'b0;
            mul_busy_reg  <= 1'b0;
            div_cnt_reg   <= '0;
            mul_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            div_busy_reg  <= div_busy_next;
            mul_busy_reg  <= mul_busy_next;
            div_cnt_reg   <= div_cnt_next;
            mul_cnt_reg   <= mul_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opcode_reg  <= opcode_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        ra_reg      <= ra_next;
        rb_reg      <= rb_next;
        acc_reg     <= acc_next;
        exp_reg     <= exp_next;
        dsr_reg     <= dsr_next;
        rem_reg     <= rem_next;
        dvs_reg     <= dvs_next;
        tv_reg      <= tv_next;
        div_dst_reg <= div_dst_next;
        neg_reg     <= neg_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        u_reg       <= u_next;
        v_reg       <= v_next;
        mc_reg      <= mc_next;
        mb_reg      <= mb_next;
        mp_reg      <= mp_next;
        mul_dst_reg <= mul_dst_next;
        out_reg     <= out_next;
    end

    always_comb
    begin
        status.busy          = div_busy_reg | mul_busy_reg;
        status.modulus_small = (modulus < RESIDUE_BITS'(2));
        status.y_zero        = (y_reg == '0);
        status.exp_zero      = (exp_reg == '0);
        status.exp_lsb       = exp_reg[0];
        status.out_free      = !out_valid_reg || !out_stall;
        status.opcode        = opcode_reg;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
`default_nettype wire

@@ sv/mau_controller.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Modular arithmetic unit controller
// Sequences reduction, multiply, Euclid and square-and-multiply steps.
// ----------------------------------------------------------------------------
module mau_controller (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   in_valid,
    output logic                  in_stall,
    input  mau_pkg::ctl_status_t  status,
    output mau_pkg::ctl_cmd_t     cmd
);
    import mau_pkg::*;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_RED_A;
                end
            end
            S_RED_A:
            begin
                if (status.modulus_small)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_WAIT;
                    ret_next   = S_RED_B;
                end
            end
            S_RED_B:
            begin
                state_next = S_WAIT;
                ret_next   = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                case (status.opcode)
                    OP_MUL:  state_next = S_MUL;
                    OP_DIV:  state_next = S_EUC_INIT;
                    OP_POW:  state_next = S_POW_INIT;
                    default: state_next = S_FINISH;
                endcase
            end
            S_MUL:
            begin
                state_next = S_WAIT;
                ret_next   = S_FINISH;
            end
            S_EUC_INIT: state_next = S_EUC_TEST;
            S_EUC_TEST:
            begin
                if (status.y_zero)
                begin
                    state_next = S_EUC_FIX;
                end
                else
                begin
                    state_next = S_WAIT;
                    ret_next   = S_EUC_TEST;
                end
            end
            S_EUC_FIX:  state_next = S_MUL;
            S_POW_INIT: state_next = S_POW_TEST;
            S_POW_TEST:
            begin
                if (status.exp_zero)
                begin
                    state_next = S_FINISH;
                end
                else if (status.exp_lsb)
                begin
                    state_next = S_POW_MUL;
                end
                else
                begin
                    state_next = S_POW_SQR;
                end
            end
            S_POW_MUL:
            begin
                state_next = S_WAIT;
                ret_next   = S_POW_SQR;
            end
            S_POW_SQR:
            begin
                state_next = S_WAIT;
                ret_next   = S_POW_TEST;
            end
            S_WAIT:
            begin
                if (!status.busy)
                begin
                    state_next = ret_reg;
                end
            end
            S_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op   = DP_NOP;
        in_stall = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                cmd.op   = in_valid ? DP_LOAD : DP_NOP;
            end
            S_RED_A:    cmd.op = status.modulus_small ? DP_NOP : DP_RED_A;
            S_RED_B:    cmd.op = DP_RED_B;
            S_MUL:      cmd.op = DP_MUL_AB;
            S_EUC_INIT: cmd.op = DP_EUC_INIT;
            S_EUC_TEST: cmd.op = status.y_zero ? DP_NOP : DP_EUC_DIV;
            S_EUC_FIX:  cmd.op = DP_EUC_FIX;
            S_POW_INIT: cmd.op = DP_POW_INIT;
            S_POW_MUL:  cmd.op = DP_MUL_CA;
            S_POW_SQR:  cmd.op = DP_MUL_AA;
            S_FINISH:   cmd.op = status.out_free ? DP_FINISH : DP_NOP;
            default:    cmd.op = DP_NOP;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

endmodule
`default_nettype wire

@@ sv/modular_arithmetic_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Modular arithmetic unit
// Modular ALU over a programmable modulus: reduce, add, sub, neg, mul, div,
// pow and compare, one result per request.
// ----------------------------------------------------------------------------
// One request at a time. Both operands are reduced by a bit-serial divider.
// Reduce, add, sub, neg and compare then finish. Multiply adds one serial
// modular multiply. Divide runs the extended Euclid loop, each step a
// serial quotient, then one multiply. Power costs up to two serial
// multiplies per exponent bit. A finished result sits in the output
// register while the next request is accepted. Write the modulus only
// while the unit is idle.
// ----------------------------------------------------------------------------
module modular_arithmetic_unit (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_stall,
    input  mau_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  wire                 out_stall,
    output mau_pkg::out_item_t  out_data,
    input  wire                 cfg_valid,
    output logic                cfg_ready,
    input  mau_pkg::residue_t   cfg_data
);
    import mau_pkg::*;

    residue_t    modulus_reg, modulus_next;
    ctl_cmd_t    cmd;
    ctl_status_t status;

    assign cfg_ready    = 1'b1;
    assign modulus_next = (cfg_valid && cfg_ready) ? cfg_data : modulus_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MODULUS_RESET;
        end
        else
        begin
            modulus_reg <= modulus_next;
        end
    end

    mau_controller u_controller (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    mau_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .modulus   (modulus_reg),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular arithmetic unit testbench
// Drives directed and random requests through the unit under several
// modulus settings and idle patterns, checking every result against a
// golden table value or an in-bench modular arithmetic predictor.
// ----------------------------------------------------------------------------
module testbench;
    import mau_pkg::*;

    localparam longint LIMIT_CYCLES = 4000000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_data;
    logic      cfg_valid;
    logic      cfg_ready;
    residue_t  cfg_data;

    residue_t  modulus_q;
    out_item_t pending_results[$];
    int        send_idle_pct;
    int        recv_stall_pct;
    bit        failed;
    longint    cycle_count;

    modular_arithmetic_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [63:0] residue_of(logic [63:0] raw, logic [63:0] m);
        logic [63:0] r;
        if (!raw[63])
        begin
            return raw % m;
        end
        r = (~raw + 64'd1) % m;
        return (r == 0) ? 64'd0 : m - r;
    endfunction

    function automatic logic [63:0] mod_mul(logic [63:0] a, logic [63:0] b,
                                            logic [63:0] m);
        return (a * b) % m;
    endfunction

    function automatic logic [63:0] mod_inverse(logic [63:0] b, logic [63:0] m);
        longint x;
        longint y;
        longint u;
        longint v;
        longint t;
        longint tmp;
        x = b;
        y = m;
        u = 1;
        v = 0;
        while (y != 0)
        begin
            t = x / y;
            x = x - t * y;
            tmp = x; x = y; y = tmp;
            u = u - t * v;
            tmp = u; u = v; v = tmp;
        end
        return residue_of(u, m);
    endfunction

    function automatic logic [63:0] mod_power(logic [63:0] base, logic [63:0] e,
                                              logic [63:0] m);
        logic [63:0] acc;
        acc = 64'd1 % m;
        if (e[63] || e == 0)
        begin
            return acc;
        end
        while (e != 0)
        begin
            if (e[0])
            begin
                acc = mod_mul(acc, base, m);
            end
            base = mod_mul(base, base, m);
            e = e >> 1;
        end
        return acc;
    endfunction

    function automatic out_item_t modular_result(in_item_t req, residue_t modv);
        out_item_t   r;
        logic [63:0] m;
        logic [63:0] ra;
        logic [63:0] rb;
        logic [63:0] v;
        r = '0;
        m = {33'd0, modv};
        if (m < 2)
        begin
            return r;
        end
        ra = residue_of(req.operand_a, m);
        rb = residue_of(req.operand_b, m);
        v = 0;
        case (req.opcode)
            OP_REDUCE: v = ra;
            OP_ADD:    v = (ra + rb) % m;
            OP_SUB:    v = (ra >= rb) ? ra - rb : ra + m - rb;
            OP_NEG:    v = (ra == 0) ? 64'd0 : m - ra;
            OP_MUL:    v = mod_mul(ra, rb, m);
            OP_DIV:    v = mod_mul(ra, mod_inverse(rb, m), m);
            OP_POW:    v = mod_power(ra, req.operand_b, m);
            default:
            begin
                r.equal = (ra == rb);
                r.less_than = (ra < rb);
            end
        endcase
        r.result = v[RESIDUE_BITS-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------
    task automatic send_request(in_item_t req);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        // drop valid, then wait for the clock before the next drive
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic predict_and_send(in_item_t req);
        pending_results.push_back(modular_result(req, modulus_q));
        send_request(req);
    endtask

    task automatic drain_results();
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
    endtask

    task automatic write_modulus(residue_t value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        modulus_q = value;
    endtask

    function automatic logic [63:0] random_wide();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(3))
            0: v = $urandom_range(20);
            1: v = -$signed({32'd0, $urandom_range(20)});
            default: ;
        endcase
        return v;
    endfunction

    function automatic in_item_t random_request();
        in_item_t req;
        req.opcode    = opcode_t'($urandom_range(7));
        req.operand_a = random_wide();
        req.operand_b = random_wide();
        // keep most exponents short so the run stays fast
        if (req.opcode == OP_POW && $urandom_range(9) != 0)
        begin
            req.operand_b = $signed({56'd0, 8'($urandom)}) - 64'sd8;
        end
        return req;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected transfer, actual %h", $time, out_data);
                failed = 1'b1;
            end
            else
            begin
                if (out_data.result !== pending_results[0].result ||
                    out_data.equal !== pending_results[0].equal ||
                    out_data.less_than !== pending_results[0].less_than)
                begin
                    $display("%0t: mismatch, expected %h actual %h", $time,
                             pending_results[0], out_data);
                    failed = 1'b1;
                end
                void'(pending_results.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------
    typedef struct {
        in_item_t  req;
        bit        known;
        out_item_t golden;
    } stim_row_t;

    localparam logic [63:0] MAXV = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] MINV = 64'h8000_0000_0000_0000;

    stim_row_t directed_rows[] = '{
        '{'{OP_REDUCE, 64'd0, 64'd0}, 1, '{31'd0, 1'b0, 1'b0}},
        '{'{OP_REDUCE, -64'sd1, 64'd0}, 1, '{31'd1000000006, 1'b0, 1'b0}},
        '{'{OP_REDUCE, MAXV, 64'd0}, 0, '0},
        '{'{OP_REDUCE, MINV, 64'd0}, 0, '0},
        '{'{OP_ADD, 64'd1000000006, 64'd1}, 1, '{31'd0, 1'b0, 1'b0}},
        '{'{OP_ADD, MAXV, MINV}, 0, '0},
        '{'{OP_SUB, 64'd0, 64'd1}, 1, '{31'd1000000006, 1'b0, 1'b0}},
        '{'{OP_SUB, MINV, MAXV}, 0, '0},
        '{'{OP_NEG, 64'd0, 64'd0}, 1, '{31'd0, 1'b0, 1'b0}},
        '{'{OP_NEG, 64'd1, 64'd0}, 1, '{31'd1000000006, 1'b0, 1'b0}},
        '{'{OP_MUL, -64'sd1, -64'sd1}, 1, '{31'd1, 1'b0, 1'b0}},
        '{'{OP_MUL, MAXV, MAXV}, 0, '0},
        '{'{OP_DIV, 64'd7, 64'd0}, 1, '{31'd0, 1'b0, 1'b0}},
        '{'{OP_DIV, 64'd6, 64'd3}, 1, '{31'd2, 1'b0, 1'b0}},
        '{'{OP_DIV, MINV, MAXV}, 0, '0},
        '{'{OP_POW, 64'd5, 64'd0}, 1, '{31'd1, 1'b0, 1'b0}},
        '{'{OP_POW, 64'd5, -64'sd3}, 1, '{31'd1, 1'b0, 1'b0}},
        '{'{OP_POW, 64'd2, 64'd10}, 1, '{31'd1024, 1'b0, 1'b0}},
        '{'{OP_POW, MINV, MAXV}, 0, '0},
        '{'{OP_COMPARE, 64'd3, 64'd3}, 1, '{31'd0, 1'b1, 1'b0}},
        '{'{OP_COMPARE, 64'd2, 64'd3}, 1, '{31'd0, 1'b0, 1'b1}},
        '{'{OP_COMPARE, -64'sd1, 64'd0}, 1, '{31'd0, 1'b0, 1'b0}}
    };

    task automatic random_phase(int count);
        repeat (count)
        begin
            predict_and_send(random_request());
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        out_stall      = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        failed         = 1'b0;
        cycle_count    = 0;
        modulus_q      = MODULUS_RESET;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            pending_results.push_back(directed_rows[i].known ? directed_rows[i].golden
                : modular_result(directed_rows[i].req, modulus_q));
            send_request(directed_rows[i].req);
        end
        random_phase(20);
        // hold off until every result is back
        drain_results();

        send_idle_pct = 52;
        write_modulus(31'h7fff_ffff);
        random_phase(25);
        drain_results();

        recv_stall_pct = 52;
        send_idle_pct  = 0;
        write_modulus(31'd2);
        random_phase(20);
        drain_results();

        // non-prime modulus exercises the non-invertible divisor path
        send_idle_pct  = 25;
        recv_stall_pct = 25;
        write_modulus(31'd12);
        random_phase(20);
        drain_results();

        // below two: every field reads zero
        write_modulus(31'd1);
        random_phase(10);
        drain_results();
        write_modulus(31'd0);
        random_phase(5);
        drain_results();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_modulus(31'($urandom_range(32'h7fff_ffff, 3)));
        random_phase(25);
        drain_results();

        if (!failed)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
sv/mau_pkg.sv
sv/mau_datapath.sv
sv/mau_controller.sv
sv/modular_arithmetic_unit.sv
tb/testbench.sv
